@@ rtl/core/smeu_pkg.sv @@
// Package: opcodes, status codes and default sizes of the stack machine execute unit.
`timescale 1ns / 1ps
package smeu_pkg;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int RET_DEPTH_DEF   = 16;
    localparam int RAM_WORDS_DEF   = 128;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int PC_WIDTH_DEF    = 16;

    localparam logic [4:0] OP_PUSH    = 5'd0;
    localparam logic [4:0] OP_ADD     = 5'd1;
    localparam logic [4:0] OP_SUB     = 5'd2;
    localparam logic [4:0] OP_DIV     = 5'd3;
    localparam logic [4:0] OP_MUL     = 5'd4;
    localparam logic [4:0] OP_POP     = 5'd5;
    localparam logic [4:0] OP_OUT     = 5'd6;
    localparam logic [4:0] OP_JMP     = 5'd7;
    localparam logic [4:0] OP_JB      = 5'd8;
    localparam logic [4:0] OP_JBE     = 5'd9;
    localparam logic [4:0] OP_JA      = 5'd10;
    localparam logic [4:0] OP_JAE     = 5'd11;
    localparam logic [4:0] OP_JE      = 5'd12;
    localparam logic [4:0] OP_JNE     = 5'd13;
    localparam logic [4:0] OP_CALL    = 5'd14;
    localparam logic [4:0] OP_RET     = 5'd15;
    localparam logic [4:0] OP_IN      = 5'd16;
    localparam logic [4:0] OP_PUSHREG = 5'd17;
    localparam logic [4:0] OP_POPREG  = 5'd18;
    localparam logic [4:0] OP_PUSHRAM = 5'd19;
    localparam logic [4:0] OP_POPRAM  = 5'd20;
    localparam logic [4:0] OP_SQRT    = 5'd21;
    localparam logic [4:0] OP_NOROOTS = 5'd22;
    localparam logic [4:0] OP_ALLNUM  = 5'd23;
    localparam logic [4:0] OP_HLT     = 5'd24;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_HALTED  = 4'd1;
    localparam logic [3:0] ST_DIVZERO = 4'd2;
    localparam logic [3:0] ST_SQRTNEG = 4'd3;
    localparam logic [3:0] ST_RAMRNG  = 4'd4;
    localparam logic [3:0] ST_BADOP   = 4'd5;
    localparam logic [3:0] ST_UNDER   = 4'd6;
    localparam logic [3:0] ST_OVER    = 4'd7;
    localparam logic [3:0] ST_NOROOTS = 4'd8;
    localparam logic [3:0] ST_ALLNUM  = 4'd9;

    localparam logic [1:0] DIV_SDIV = 2'd0;
    localparam logic [1:0] DIV_MUL  = 2'd1;
    localparam logic [1:0] DIV_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] mode;
    } ctl_t;
endpackage

@@ rtl/core/smeu_divsqrt.sv @@
// Iterative unit: signed 2W/W divide, quotient by scale, and integer square root.
`timescale 1ns / 1ps
module smeu_divsqrt #(
    parameter int DATA_WIDTH = smeu_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smeu_pkg::ctl_t              ctl,
    input  logic signed [2*DATA_WIDTH-1:0] num,
    input  logic signed [DATA_WIDTH:0]  den,
    output logic                        done,
    output logic [DATA_WIDTH-1:0]       result
);
    import smeu_pkg::*;
    localparam int NW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(NW + 1);

    logic [1:0]          mode_reg;
    logic                busy_reg;
    logic [CW-1:0]       cnt_reg;
    logic [NW-1:0]       n_reg;
    logic [NW:0]         rem_reg;
    logic [NW-1:0]       q_reg;
    logic [DATA_WIDTH:0] d_reg;
    logic                neg_reg;
    logic [NW+1:0]       sqr_reg;
    logic [NW-1:0]       root_reg;

    logic [NW:0]   rem_sh;
    logic [NW+1:0] trial;
    logic [NW+1:0] sqr_sh;
    logic [NW-1:0] qneg;

    always_comb
    begin
        rem_sh = {rem_reg[NW-1:0], n_reg[NW-1]};
        sqr_sh = {sqr_reg[NW-1:0], n_reg[NW-1:NW-2]};
        trial  = {root_reg, 2'b01};
        qneg   = neg_reg ? (~q_reg + 1'b1) : q_reg;
        result = (mode_reg == DIV_SQRT) ? root_reg[DATA_WIDTH-1:0] : qneg[DATA_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= DIV_SDIV;
        end
        else
        begin
            done <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= ctl.mode;
                cnt_reg  <= (ctl.mode == DIV_SQRT) ? CW'(NW / 2) : CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            neg_reg  <= num[NW-1] ^ den[DATA_WIDTH];
            n_reg    <= (ctl.mode == DIV_SQRT) ? num :
                        (num[NW-1] ? (~num + 1'b1) : num);
            d_reg    <= den[DATA_WIDTH] ? (~den + 1'b1) : den;
            rem_reg  <= '0;
            q_reg    <= '0;
            sqr_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mode_reg == DIV_SQRT)
            begin
                n_reg <= {n_reg[NW-3:0], 2'b00};
                if (sqr_sh >= trial)
                begin
                    sqr_reg  <= sqr_sh - trial;
                    root_reg <= {root_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    sqr_reg  <= sqr_sh;
                    root_reg <= {root_reg[NW-2:0], 1'b0};
                end
            end
            else
            begin
                n_reg <= {n_reg[NW-2:0], 1'b0};
                if (rem_sh >= {{(NW-DATA_WIDTH){1'b0}}, d_reg})
                begin
                    rem_reg <= rem_sh - {{(NW-DATA_WIDTH){1'b0}}, d_reg};
                    q_reg   <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[NW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

@@ rtl/core/stack_machine_execute_unit_top.sv @@
// Top level: sequencer, stack and RAM memories, registers and stream/APB ports.
// Sequence: address, memory read, execute and output states for most instructions; div,
//   mul, sqrt and a register-offset RAM access also wait on the iterative divider.
// Flow: one instruction at a time, the next accepted only once the unit is idle again.
// Reset: clearing pass over every data RAM word, no item accepted meanwhile.
// Reset also clears stack pointers, registers, fault bit; scale_factor returns to 100.
`timescale 1ns / 1ps
module stack_machine_execute_unit_top #(
    parameter int STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
    parameter int RET_DEPTH   = smeu_pkg::RET_DEPTH_DEF,
    parameter int RAM_WORDS   = smeu_pkg::RAM_WORDS_DEF,
    parameter int DATA_WIDTH  = smeu_pkg::DATA_WIDTH_DEF,
    parameter int PC_WIDTH    = smeu_pkg::PC_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[4:0], instr_pc[20:5], immediate[52:21], reg_index[54:53],
    // reg_given[55], in_value[87:56]
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[15:0], out_valid[16], out_value[48:17], status[52:49]
    output logic [55:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import smeu_pkg::*;
    localparam int DW  = DATA_WIDTH;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int STW = $clog2(STACK_DEPTH + 1);
    localparam int RAW = $clog2(RET_DEPTH);
    localparam int RTW = $clog2(RET_DEPTH + 1);
    localparam int MAW = $clog2(RAM_WORDS);
    localparam int MCW = $clog2(RAM_WORDS + 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // stores
    logic [DW-1:0]       dstk [STACK_DEPTH];
    logic [PC_WIDTH-1:0] rstk [RET_DEPTH];
    logic [DW-1:0]       dram [RAM_WORDS];
    logic [DW-1:0]       gregs_reg [4];

    logic [2:0]  state_reg;
    logic [15:0] scale_reg;
    logic        fault_reg;
    logic [STW-1:0] dtop_reg;
    logic [RTW-1:0] rtop_reg;
    logic [MCW-1:0] clr_reg;

    logic [4:0]  op_reg;
    logic [15:0] pc_reg;
    logic signed [31:0] imm_reg;
    logic [1:0]  ri_reg;
    logic        rg_reg;
    logic signed [31:0] inv_reg;

    logic [DW-1:0] top_q, sec_q, ram_q;
    logic [PC_WIDTH-1:0] ret_q;
    logic signed [DW+16:0] addr_reg;
    logic [1:0] pass_reg;

    logic [15:0] out_pc_reg;
    logic        ov_reg;
    logic [31:0] ovv_reg;
    logic [3:0]  st_reg;
    logic        mval_reg;
    logic [55:0] m_data_reg;

    // divider for register offset and arithmetic
    ctl_t ctl;
    logic signed [2*DW-1:0] dnum;
    logic signed [DW:0]     dden;
    logic                   ddone;
    logic [DW-1:0]          dres;
    logic signed [2*DW-1:0] prod_reg;

    smeu_divsqrt #(.DATA_WIDTH(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .num(dnum), .den(dden),
        .done(ddone), .result(dres)
    );

    logic [15:0] scale_eff;
    assign scale_eff = (scale_reg == 16'd0) ? 16'd1 : scale_reg;
    assign pready    = 1'b1;
    assign prdata    = {16'd0, scale_reg};
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mval_reg;
    assign m_tdata   = m_data_reg;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    logic [PC_WIDTH-1:0] pcw, tgt;
    assign pcw = PC_WIDTH'(pc_reg);
    assign tgt = PC_WIDTH'(imm_reg);

    logic signed [DW-1:0] a_s, b_s;
    assign a_s = sec_q;
    assign b_s = top_q;

    logic is_bin;
    assign is_bin = (op_reg <= OP_MUL && op_reg != OP_PUSH) ||
                    (op_reg >= OP_JB && op_reg <= OP_JNE);

    // execute decision (combinational, uses registered memory data)
    logic [3:0] ex_st;
    logic [PC_WIDTH-1:0] ex_next;
    logic ex_div;
    logic [1:0] ex_mode;
    logic take;
    logic ram_in;

    always_comb
    begin
        ex_st   = ST_OK;
        ex_next = pcw + PC_WIDTH'(1);
        ex_div  = 1'b0;
        ex_mode = DIV_SDIV;
        take    = 1'b0;
        ram_in  = (addr_reg >= 0) && (addr_reg < (DW+17)'(RAM_WORDS));
        unique case (op_reg)
            OP_JB:   take = a_s <  b_s;
            OP_JBE:  take = a_s <= b_s;
            OP_JA:   take = a_s >  b_s;
            OP_JAE:  take = a_s >= b_s;
            OP_JE:   take = a_s == b_s;
            default: take = a_s != b_s;
        endcase
        if (fault_reg)
        begin
            ex_st = ST_HALTED;
        end
        else if (op_reg == OP_PUSH)
        begin
            if (dtop_reg >= STW'(STACK_DEPTH)) ex_st = ST_OVER;
            else ex_next = pcw + PC_WIDTH'(2);
        end
        else if (is_bin)
        begin
            if (dtop_reg < STW'(2)) ex_st = ST_UNDER;
            else if (op_reg >= OP_JB) ex_next = take ? tgt : pcw + PC_WIDTH'(2);
            else if (op_reg == OP_DIV && b_s == '0) ex_st = ST_DIVZERO;
            else if (op_reg == OP_DIV || op_reg == OP_MUL)
            begin
                ex_div  = 1'b1;
                ex_mode = (op_reg == OP_DIV) ? DIV_SDIV : DIV_MUL;
            end
        end
        else if (op_reg == OP_POP || op_reg == OP_OUT)
        begin
            if (dtop_reg == '0) ex_st = ST_UNDER;
        end
        else if (op_reg == OP_JMP) ex_next = tgt;
        else if (op_reg == OP_CALL)
        begin
            if (rtop_reg >= RTW'(RET_DEPTH)) ex_st = ST_OVER;
            else ex_next = tgt;
        end
        else if (op_reg == OP_RET)
        begin
            if (rtop_reg == '0) ex_st = ST_UNDER;
            else ex_next = ret_q + PC_WIDTH'(1);
        end
        else if (op_reg == OP_IN || op_reg == OP_PUSHREG)
        begin
            if (dtop_reg >= STW'(STACK_DEPTH)) ex_st = ST_OVER;
            else if (op_reg == OP_PUSHREG) ex_next = pcw + PC_WIDTH'(2);
        end
        else if (op_reg == OP_POPREG)
        begin
            if (dtop_reg == '0) ex_st = ST_UNDER;
            else ex_next = pcw + PC_WIDTH'(2);
        end
        else if (op_reg == OP_PUSHRAM || op_reg == OP_POPRAM)
        begin
            if (!ram_in) ex_st = ST_RAMRNG;
            else if (op_reg == OP_PUSHRAM && dtop_reg >= STW'(STACK_DEPTH)) ex_st = ST_OVER;
            else if (op_reg == OP_POPRAM && dtop_reg == '0) ex_st = ST_UNDER;
            else ex_next = pcw + (rg_reg ? PC_WIDTH'(3) : PC_WIDTH'(2));
        end
        else if (op_reg == OP_SQRT)
        begin
            if (dtop_reg == '0) ex_st = ST_UNDER;
            else if (b_s < 0) ex_st = ST_SQRTNEG;
            else
            begin
                ex_div  = 1'b1;
                ex_mode = DIV_SQRT;
            end
        end
        else if (op_reg == OP_NOROOTS) ex_st = ST_NOROOTS;
        else if (op_reg == OP_ALLNUM)  ex_st = ST_ALLNUM;
        else if (op_reg == OP_HLT)     ex_st = ST_HALTED;
        else ex_st = ST_BADOP;
        if (ex_st != ST_OK && ex_st != ST_NOROOTS && ex_st != ST_ALLNUM)
            ex_next = pcw;
    end

    // divider operand selection
    logic signed [2*DW-1:0] greg_ext;
    always_comb
    begin
        greg_ext = {{DW{gregs_reg[ri_reg][DW-1]}}, gregs_reg[ri_reg]};
        ctl      = '{start: 1'b0, mode: DIV_SDIV};
        dnum     = greg_ext;
        dden     = (DW+1)'(scale_eff);
        if (state_reg == S_ADDR && rg_reg &&
            (op_reg == OP_PUSHRAM || op_reg == OP_POPRAM) && !fault_reg)
        begin
            ctl.start = 1'b1;
        end
        else if (state_reg == S_EXEC && pass_reg == 2'd1)
        begin
            ctl.start = 1'b1;
            ctl.mode  = (op_reg == OP_DIV) ? DIV_SDIV :
                        (op_reg == OP_MUL) ? DIV_MUL : DIV_SQRT;
            dnum      = prod_reg;
            dden      = (op_reg == OP_DIV) ? {b_s[DW-1], b_s} : (DW+1)'(scale_eff);
        end
    end

    logic [SAW-1:0] ia_top, ia_sec;
    assign ia_top = SAW'(dtop_reg - 1'b1);
    assign ia_sec = SAW'(dtop_reg - 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            scale_reg <= 16'd100;
            fault_reg <= 1'b0;
            dtop_reg  <= '0;
            rtop_reg  <= '0;
            mval_reg  <= 1'b0;
            pass_reg  <= 2'd0;
            for (int i = 0; i < 4; i++) gregs_reg[i] <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 2'd0)
                scale_reg <= pwdata[15:0];
            if (mval_reg && m_tready)
                mval_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == MCW'(RAM_WORDS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_fire) state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    // hold while the register offset is divided by scale
                    if (ctl.start) state_reg <= S_WAIT;
                    else state_reg <= S_RD;
                end
                S_WAIT:
                begin
                    if (ddone)
                    begin
                        if (pass_reg == 2'd2)
                        begin
                            pass_reg  <= 2'd0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EXEC;
                    pass_reg  <= 2'd0;
                end
                S_EXEC:
                begin
                    if (ex_div && pass_reg == 2'd0)
                    begin
                        pass_reg <= 2'd1;
                    end
                    else if (ex_div && pass_reg == 2'd1)
                    begin
                        pass_reg  <= 2'd2;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        if (ex_st != ST_OK && ex_st != ST_NOROOTS && ex_st != ST_ALLNUM)
                            fault_reg <= 1'b1;
                        else if (ex_st == ST_OK)
                        begin
                            priority if (op_reg == OP_PUSH || op_reg == OP_IN ||
                                op_reg == OP_PUSHREG || op_reg == OP_PUSHRAM)
                                dtop_reg <= dtop_reg + 1'b1;
                            else if (op_reg >= OP_JB && op_reg <= OP_JNE)
                                dtop_reg <= dtop_reg - 2'd2;
                            else if (op_reg == OP_ADD || op_reg == OP_SUB ||
                                op_reg == OP_POP || op_reg == OP_OUT ||
                                op_reg == OP_POPREG || op_reg == OP_POPRAM)
                                dtop_reg <= dtop_reg - 1'b1;
                            if (op_reg == OP_CALL) rtop_reg <= rtop_reg + 1'b1;
                            if (op_reg == OP_RET)  rtop_reg <= rtop_reg - 1'b1;
                            if (op_reg == OP_POPREG) gregs_reg[ri_reg] <= top_q;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!mval_reg)
                    begin
                        mval_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                        if ((op_reg == OP_DIV || op_reg == OP_MUL) && st_reg == ST_OK)
                            dtop_reg <= dtop_reg - 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload and memory ports
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg  <= s_tdata[4:0];
            pc_reg  <= s_tdata[20:5];
            imm_reg <= s_tdata[52:21];
            ri_reg  <= s_tdata[54:53];
            rg_reg  <= s_tdata[55];
            inv_reg <= s_tdata[87:56];
        end
        if (state_reg == S_ADDR)
            addr_reg <= (DW+17)'(imm_reg);
        if (state_reg == S_WAIT && ddone && pass_reg != 2'd2)
            addr_reg <= addr_reg + $signed({{17{dres[DW-1]}}, dres});
        if (state_reg == S_CLR)
            dram[MAW'(clr_reg)] <= '0;
        if (state_reg == S_RD)
        begin
            top_q <= dstk[ia_top];
            sec_q <= dstk[ia_sec];
            ret_q <= rstk[RAW'(rtop_reg - 1'b1)];
            ram_q <= dram[MAW'(addr_reg)];
        end
        if (state_reg == S_EXEC)
        begin
            if (pass_reg == 2'd0)
            begin
                unique case (op_reg)
                    OP_DIV:  prod_reg <= (2*DW)'(a_s) * $signed({1'b0, scale_eff});
                    OP_MUL:  prod_reg <= (2*DW)'(a_s) * (2*DW)'(b_s);
                    default: prod_reg <= (2*DW)'(b_s) * $signed({1'b0, scale_eff});
                endcase
            end
            if (!ex_div && ex_st == ST_OK && !fault_reg)
            begin
                unique case (op_reg)
                    OP_PUSH:    dstk[SAW'(dtop_reg)] <= DW'(imm_reg);
                    OP_IN:      dstk[SAW'(dtop_reg)] <= DW'(inv_reg);
                    OP_PUSHREG: dstk[SAW'(dtop_reg)] <= gregs_reg[ri_reg];
                    OP_PUSHRAM: dstk[SAW'(dtop_reg)] <= ram_q;
                    OP_ADD:     dstk[ia_sec] <= sec_q + top_q;
                    OP_SUB:     dstk[ia_sec] <= sec_q - top_q;
                    OP_POPRAM:  dram[MAW'(addr_reg)] <= top_q;
                    OP_CALL:    rstk[RAW'(rtop_reg)] <= pcw + PC_WIDTH'(1);
                    default:    ;
                endcase
            end
            out_pc_reg <= 16'(ex_next);
            ov_reg     <= (op_reg == OP_OUT) && ex_st == ST_OK;
            ovv_reg    <= ((op_reg == OP_OUT) && ex_st == ST_OK) ? 32'(top_q) : 32'd0;
            st_reg     <= ex_st;
        end
        if (state_reg == S_WAIT && ddone && pass_reg == 2'd2)
        begin
            if (op_reg == OP_SQRT) dstk[ia_top] <= dres;
            else dstk[ia_sec] <= dres;
        end
        // load the output register once the previous result has left
        if (state_reg == S_OUT && !mval_reg)
            m_data_reg <= {3'd0, st_reg, ovv_reg, ov_reg, out_pc_reg};
    end
endmodule

@@ rtl/core/smeu_checker.sv @@
// Port checker for the execute unit, bound to the top level.
`timescale 1ns / 1ps
module smeu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import smeu_pkg::*;
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an instruction is in flight");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[52:49] <= ST_ALLNUM)
        else $error("status code out of range");
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[16] |-> m_tdata[48:17] == 32'd0)
        else $error("out value without out flag");
endmodule

bind stack_machine_execute_unit_top smeu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ verif/stack_machine_execute_unit_checker.sv @@
// Checker: predicts the stack machine execute unit per instruction and compares its results.
`timescale 1ns / 1ps
module stack_machine_execute_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import smeu_pkg::*;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] out_value;
        logic        out_valid;
        logic [15:0] next_pc;
    } exec_result_t;

    exec_result_t result_q[$];

    logic signed [31:0] dstk [64];
    int unsigned        dtop;
    logic [15:0]        rstk [16];
    int unsigned        rtop;
    logic signed [31:0] gregs [4];
    logic signed [31:0] ram [128];
    bit                 halted;
    logic [15:0]        scale;

    assign pending = result_q.size();

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic exec_result_t execute(input logic [87:0] d);
        exec_result_t       res;
        logic [4:0]         op;
        logic [15:0]        pc;
        logic signed [31:0] imm;
        logic [1:0]         ri;
        logic               rg;
        logic signed [31:0] inv;
        longint             sc;
        longint             a;
        longint             b;
        longint             r;
        longint             addr;
        logic [15:0]        nxt;
        logic [3:0]         st;
        bit                 take;
        op  = d[4:0];
        pc  = d[20:5];
        imm = d[52:21];
        ri  = d[54:53];
        rg  = d[55];
        inv = d[87:56];
        sc  = (scale == 0) ? 1 : longint'(scale);
        nxt = pc + 16'd1;
        st  = ST_OK;
        res = '0;
        if (halted)
        begin
            nxt = pc;
            st  = ST_HALTED;
        end
        else
        begin
            case (op)
                OP_PUSH:
                    if (dtop >= 64) st = ST_OVER;
                    else
                    begin
                        dstk[dtop] = imm;
                        dtop++;
                        nxt = pc + 16'd2;
                    end
                OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE:
                    if (dtop < 2) st = ST_UNDER;
                    else
                    begin
                        b = dstk[dtop - 1];
                        a = dstk[dtop - 2];
                        if (op >= OP_JB)
                        begin
                            case (op)
                                OP_JB:   take = a < b;
                                OP_JBE:  take = a <= b;
                                OP_JA:   take = a > b;
                                OP_JAE:  take = a >= b;
                                OP_JE:   take = a == b;
                                default: take = a != b;
                            endcase
                            dtop -= 2;
                            nxt = take ? imm[15:0] : pc + 16'd2;
                        end
                        else if (op == OP_DIV && b == 0)
                            st = ST_DIVZERO;
                        else
                        begin
                            case (op)
                                OP_ADD:  r = a + b;
                                OP_SUB:  r = a - b;
                                OP_MUL:  r = (a * b) / sc;
                                default: r = (a * sc) / b;
                            endcase
                            dtop--;
                            dstk[dtop - 1] = r[31:0];
                        end
                    end
                OP_POP, OP_OUT:
                    if (dtop == 0) st = ST_UNDER;
                    else
                    begin
                        dtop--;
                        if (op == OP_OUT)
                        begin
                            res.out_valid = 1'b1;
                            res.out_value = dstk[dtop];
                        end
                    end
                OP_JMP:
                    nxt = imm[15:0];
                OP_CALL:
                    if (rtop >= 16) st = ST_OVER;
                    else
                    begin
                        rstk[rtop] = pc + 16'd1;
                        rtop++;
                        nxt = imm[15:0];
                    end
                OP_RET:
                    if (rtop == 0) st = ST_UNDER;
                    else
                    begin
                        rtop--;
                        nxt = rstk[rtop] + 16'd1;
                    end
                OP_IN, OP_PUSHREG:
                    if (dtop >= 64) st = ST_OVER;
                    else
                    begin
                        dstk[dtop] = (op == OP_IN) ? inv : gregs[ri];
                        dtop++;
                        nxt = (op == OP_IN) ? pc + 16'd1 : pc + 16'd2;
                    end
                OP_POPREG:
                    if (dtop == 0) st = ST_UNDER;
                    else
                    begin
                        dtop--;
                        gregs[ri] = dstk[dtop];
                        nxt = pc + 16'd2;
                    end
                OP_PUSHRAM, OP_POPRAM:
                begin
                    addr = imm;
                    if (rg)
                        addr += longint'(gregs[ri]) / sc;
                    if (addr < 0 || addr >= 128) st = ST_RAMRNG;
                    else if (op == OP_PUSHRAM && dtop >= 64) st = ST_OVER;
                    else if (op == OP_POPRAM && dtop == 0) st = ST_UNDER;
                    else
                    begin
                        if (op == OP_PUSHRAM)
                        begin
                            dstk[dtop] = ram[addr];
                            dtop++;
                        end
                        else
                        begin
                            dtop--;
                            ram[addr] = dstk[dtop];
                        end
                        nxt = rg ? pc + 16'd3 : pc + 16'd2;
                    end
                end
                OP_SQRT:
                    if (dtop == 0) st = ST_UNDER;
                    else if (dstk[dtop - 1] < 0) st = ST_SQRTNEG;
                    else
                    begin
                        r = int_sqrt(longint'(dstk[dtop - 1]) * sc);
                        dstk[dtop - 1] = r[31:0];
                    end
                OP_NOROOTS: st = ST_NOROOTS;
                OP_ALLNUM:  st = ST_ALLNUM;
                OP_HLT:
                begin
                    st = ST_HALTED;
                    halted = 1'b1;
                    nxt = pc;
                end
                default:    st = ST_BADOP;
            endcase
            if (st >= ST_DIVZERO && st <= ST_OVER)
            begin
                halted = 1'b1;
                nxt = pc;
            end
        end
        res.next_pc = nxt;
        res.status  = st;
        return res;
    endfunction

    initial
    begin
        errors = 0;
        dtop   = 0;
        rtop   = 0;
        halted = 1'b0;
        scale  = 16'd100;
        foreach (gregs[i]) gregs[i] = '0;
        foreach (ram[i]) ram[i] = '0;
    end

    always @(posedge clk)
    begin
        exec_result_t got;
        exec_result_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                scale = pwdata[15:0];
            if (s_tvalid && s_tready)
                result_q.push_back(execute(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[52:0];
                if (result_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = result_q.pop_front();
                    if (got.next_pc !== want.next_pc)
                        report_mismatch($sformatf("next_pc %h, want %h",
                                                  got.next_pc, want.next_pc));
                    if (got.out_valid !== want.out_valid)
                        report_mismatch($sformatf("out_valid %b, want %b",
                                                  got.out_valid, want.out_valid));
                    if (got.out_value !== want.out_value)
                        report_mismatch($sformatf("out_value %h, want %h",
                                                  got.out_value, want.out_value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                end
            end
        end
    end
endmodule

@@ verif/tb_stack_machine_execute_unit_top.sv @@
// Testbench top: drives instructions and scale settings into the execute unit and gives the verdict.
`timescale 1ns / 1ps
module tb_stack_machine_execute_unit_top;
    import smeu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;

    int          depth;
    int          ret_depth;
    int          scale_eff;
    int          burst_left;
    int          cyc;

    stack_machine_execute_unit_top dut (.*);

    stack_machine_execute_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver stall pattern: m_tready steps through always ready, random, toggling and mostly low modes.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        case ((cyc >> 6) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            2:       m_tready <= cyc[2];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Present one instruction, hold it until the transfer, then keep tvalid high or drop it for a random gap.
    task automatic issue(input logic [4:0] op, input logic [15:0] pc, input logic [31:0] imm,
                         input logic [1:0] ri, input logic rg, input logic [31:0] inv);
        s_tvalid <= 1'b1;
        s_tdata  <= {inv, rg, ri, imm, pc, op};
        do
            @(posedge clk);
        while (!s_tready);
        case (op)
            OP_PUSH, OP_IN, OP_PUSHREG, OP_PUSHRAM:             depth++;
            OP_POP, OP_OUT, OP_POPREG, OP_POPRAM, OP_ADD, OP_SUB,
            OP_MUL, OP_DIV:                                     depth--;
            OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE:        depth -= 2;
            OP_CALL:                                            ret_depth++;
            OP_RET:                                             ret_depth--;
            default: ;
        endcase
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        scale_eff = (value == 0) ? 1 : value;
    endtask

    // One well-formed random instruction or short sequence that cannot fault.
    task automatic random_step;
        int  pick;
        int  off;
        int  tgt;
        int  val;
        logic [1:0] ri;
        pick = $urandom_range(0, 99);
        ri   = $urandom_range(0, 3);
        if (depth < 8 && pick < 50)
            pick = 0;
        if (depth > 56 && pick < 30)
            pick = 35;
        if (pick < 14 && depth < 64)
            issue(OP_PUSH, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 20 && depth < 64)
            issue(OP_IN, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 30 && depth >= 2)
            issue($urandom_range(0, 2) == 0 ? OP_ADD : ($urandom_range(0, 1) ? OP_SUB : OP_MUL),
                  $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 35 && depth >= 1 && depth < 64)
        begin
            issue(OP_PUSH, $urandom, $urandom_range(1, 40000) * ($urandom_range(0, 1) ? 1 : -1),
                  ri, 0, $urandom);
            issue(OP_DIV, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        end
        else if (pick < 42 && depth >= 1)
            issue($urandom_range(0, 1) ? OP_OUT : OP_POP, $urandom, $urandom, ri,
                  $urandom_range(0, 1), $urandom);
        else if (pick < 48 && depth < 64)
        begin
            issue(OP_PUSH, $urandom, {1'b0, 31'($urandom)}, ri, 0, $urandom);
            issue(OP_SQRT, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        end
        else if (pick < 58 && depth >= 2)
        begin
            // Equal operands now and then so je/jbe/jae take their equal branch.
            if ($urandom_range(0, 2) == 0 && depth < 63)
            begin
                tgt = $urandom;
                issue(OP_PUSH, $urandom, tgt, ri, 0, $urandom);
                issue(OP_PUSH, $urandom, tgt, ri, 0, $urandom);
            end
            issue($urandom_range(OP_JB, OP_JNE), $urandom, $urandom, ri,
                  $urandom_range(0, 1), $urandom);
        end
        else if (pick < 61)
            issue(OP_JMP, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 66 && ret_depth < 16)
            issue(OP_CALL, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 71 && ret_depth >= 1)
            issue(OP_RET, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 75 && depth < 64)
            issue(OP_PUSHREG, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 78 && depth >= 1)
            issue(OP_POPREG, $urandom, $urandom, ri, $urandom_range(0, 1), $urandom);
        else if (pick < 85 && depth >= 1 && depth < 64)
            issue($urandom_range(0, 1) ? OP_PUSHRAM : OP_POPRAM, $urandom,
                  $urandom_range(0, 127), ri, 0, $urandom);
        else if (pick < 94 && depth >= 1 && depth < 63)
        begin
            // Load an offset register, then address RAM through it.
            off = $urandom_range(0, 60) - 20;
            tgt = $urandom_range(0, 127);
            val = off * scale_eff + ($urandom_range(0, 1) ? 0 : off);
            issue(OP_PUSH, $urandom, val, ri, 0, $urandom);
            issue(OP_POPREG, $urandom, $urandom, ri, 0, $urandom);
            // Base minus the truncated offset lands on the chosen word.
            issue($urandom_range(0, 1) ? OP_PUSHRAM : OP_POPRAM, $urandom,
                  tgt - val / scale_eff, ri, 1, $urandom);
        end
        else if (pick < 97)
            issue($urandom_range(0, 1) ? OP_NOROOTS : OP_ALLNUM, $urandom, $urandom, ri,
                  $urandom_range(0, 1), $urandom);
        else if (depth < 64)
            issue(OP_PUSH, $urandom, $urandom, ri, 0, $urandom);
        else
            issue(OP_POP, $urandom, $urandom, ri, 0, $urandom);
    endtask

    initial
    begin
        int n;
        logic [15:0] phase_scale [6];
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        depth      = 0;
        ret_depth  = 0;
        scale_eff  = 100;
        burst_left = 0;
        cyc        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and the non-faulting opcodes except pop and jb/jbe/ja/jae/jne, at reset scale.
        issue(OP_PUSH,    16'h0000, 32'h7FFF_FFFF, 2'd0, 0, 32'h0);
        issue(OP_PUSH,    16'hFFFF, 32'h8000_0000, 2'd3, 1, 32'hFFFF_FFFF);
        issue(OP_ADD,     16'hFFFF, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_IN,      16'hFFFF, 32'h0,         2'd1, 0, 32'h7FFF_FFFF);
        issue(OP_IN,      16'h1234, 32'h0,         2'd2, 0, 32'h8000_0000);
        issue(OP_SUB,     16'h0001, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_PUSH,    16'h0002, 32'h7FFF_FFFF, 2'd0, 0, 32'h0);
        issue(OP_MUL,     16'h0003, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_PUSH,    16'h0004, 32'hFFFF_FFFF, 2'd0, 0, 32'h0);
        issue(OP_DIV,     16'h0005, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_OUT,     16'h0006, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_PUSH,    16'h0007, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_SQRT,    16'h0008, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_POPREG,  16'h0009, 32'h0,         2'd3, 0, 32'h0);
        issue(OP_PUSHREG, 16'h000A, 32'h0,         2'd3, 0, 32'h0);
        issue(OP_POPRAM,  16'h000B, 32'd127,       2'd0, 0, 32'h0);
        issue(OP_PUSHRAM, 16'h000C, 32'd127,       2'd0, 0, 32'h0);
        issue(OP_PUSHRAM, 16'h000D, 32'd0,         2'd3, 1, 32'h0);
        issue(OP_JE,      16'h000E, 32'hFFFF_ABCD, 2'd0, 0, 32'h0);
        issue(OP_CALL,    16'hFFFF, 32'h0000_FFFF, 2'd0, 0, 32'h0);
        issue(OP_RET,     16'h0010, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_JMP,     16'h0011, 32'hFFFF_FFFF, 2'd0, 0, 32'h0);
        issue(OP_NOROOTS, 16'h0012, 32'h0,         2'd0, 0, 32'h0);
        issue(OP_ALLNUM,  16'h0013, 32'h0,         2'd0, 0, 32'h0);
        drain();

        // Zero scale behaves as one.
        phase_scale[0] = 16'd100;
        phase_scale[1] = 16'd1;
        phase_scale[2] = 16'd65535;
        phase_scale[3] = 16'd0;
        phase_scale[4] = $urandom_range(2, 65534);
        phase_scale[5] = $urandom_range(2, 1000);
        foreach (phase_scale[p])
        begin
            write_scale(phase_scale[p]);
            n = 0;
            while (n < 125)
            begin
                random_step();
                n++;
            end
            drain();
        end

        // One fault of a random kind, then instructions that must report halted.
        case ($urandom_range(0, 6))
            0: issue($urandom_range(25, 31), $urandom, $urandom, 0, 0, $urandom);
            1: issue(OP_HLT, $urandom, $urandom, 0, 0, $urandom);
            2:
            begin
                issue(OP_PUSH, $urandom, 32'h0, 0, 0, $urandom);
                issue(OP_DIV, $urandom, $urandom, 0, 0, $urandom);
            end
            3:
            begin
                issue(OP_PUSH, $urandom, -$urandom_range(1, 1000), 0, 0, $urandom);
                issue(OP_SQRT, $urandom, $urandom, 0, 0, $urandom);
            end
            4: issue(OP_PUSHRAM, $urandom, $urandom_range(0, 1) ? 32'd128 : 32'hFFFF_FFFF,
                     0, 0, $urandom);
            5:
            begin
                while (depth > 0)
                    issue(OP_POP, $urandom, $urandom, 0, 0, $urandom);
                issue(OP_POP, $urandom, $urandom, 0, 0, $urandom);
            end
            default:
            begin
                while (depth < 64)
                    issue(OP_PUSH, $urandom, $urandom, 0, 0, $urandom);
                issue(OP_PUSH, $urandom, $urandom, 0, 0, $urandom);
            end
        endcase
        repeat (6)
            issue($urandom_range(0, 31), $urandom, $urandom, $urandom_range(0, 3),
                  $urandom_range(0, 1), $urandom);
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
